>>> design/tbsc_pkg.sv
// Package for the table byte stuffing codec: item and configuration types,
// register indexes and the rule field helpers. No dependencies.
package tbsc_pkg;

	localparam int unsigned MaxPattern = 3;
	localparam int unsigned MaxRules   = 4;
	localparam int unsigned RuleRegs   = 4;
	localparam int unsigned RuleWidth  = 52;
	localparam int unsigned QDepth     = 4;

	typedef logic [RuleWidth-1:0] rule_t;

	typedef enum logic [2:0] {
		REG_DIRECTION  = 3'd0,
		REG_RULE_COUNT = 3'd1,
		REG_RULE_ZERO  = 3'd2,
		REG_RULE_ONE   = 3'd3,
		REG_RULE_TWO   = 3'd4,
		REG_RULE_THREE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                      direction;
		logic [2:0]                rule_count;
		rule_t [RuleRegs-1:0]      rules;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} item_t;

	// Length of the raw (escaped = 0) or escaped (escaped = 1) pattern.
	function automatic logic [1:0] pat_len(rule_t r, logic escaped);
		return escaped ? r[27:26] : r[1:0];
	endfunction

	// Byte k (0 to 2) of the raw or escaped pattern.
	function automatic logic [7:0] pat_byte(rule_t r, logic escaped, logic [1:0] k);
		logic [5:0] base;
		base = (escaped ? 6'd28 : 6'd2) + {1'b0, k, 3'b000};
		return r[base +: 8];
	endfunction

endpackage

>>> design/tbsc_if.sv
// Stream interfaces of the table byte stuffing codec: the input word channel
// and the output word channel. No dependencies.
interface tbsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;
	modport source (output valid, data_byte, end_of_frame, input ready);
	modport sink   (input valid, data_byte, end_of_frame, output ready);
endinterface

interface tbsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source (output valid, out_byte, out_last, input ready);
	modport sink   (input valid, out_byte, out_last, output ready);
endinterface

>>> design/tbsc_front.sv
// Front end of the codec: accepts input words, tags them as frame body or
// frame end and holds them in a short queue. Uses tbsc_pkg and tbsc_in_if.
module tbsc_front (
	input  logic            clk,
	input  logic            arst_n,
	tbsc_in_if.sink         rx,
	output tbsc_pkg::item_t head,
	output logic            head_valid,
	input  logic            pop
);
	import tbsc_pkg::*;

	localparam int unsigned PtrW = $clog2(QDepth);
	localparam int unsigned CntW = $clog2(QDepth + 1);

	item_t             mem_q [QDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   cnt_q;
	logic              push;
	item_t             item_in;

	assign rx.ready   = (cnt_q != CntW'(QDepth));
	assign push       = rx.valid && rx.ready;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		item_in.data_byte    = rx.data_byte;
		item_in.end_of_frame = rx.end_of_frame;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QDepth))
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CntW'(1))
		else $error("queue count did not grow on a lone push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - CntW'(1))
		else $error("queue count did not shrink on a lone pop");

endmodule

>>> design/tbsc_back.sv
// Back end of the codec: lookahead window, rule matching, replacement
// buffer and output register. Uses tbsc_pkg and tbsc_out_if.
module tbsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tbsc_pkg::cfg_t  cfg,
	input  tbsc_pkg::item_t head,
	input  logic            head_valid,
	output logic            pop,
	tbsc_out_if.source      tx
);
	import tbsc_pkg::*;

	logic [7:0] win_q [MaxPattern];
	logic [1:0] fill_q;
	logic       flush_q;
	logic [7:0] rep_q [2];
	logic [1:0] rep_cnt_q;
	logic       rep_last_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       adv;
	logic       pending;
	logic       decide;
	logic       emit_rep;
	logic [7:0] eff_win [MaxPattern];
	logic [1:0] eff_fill;
	logic       eff_flush;
	logic       frame_done;
	logic [2:0] active;
	logic       match_esc;

	logic [1:0] m_len [RuleRegs];
	logic [1:0] r_len [RuleRegs];
	logic       hit   [RuleRegs];
	logic       found;
	logic [1:0] sel_ml;
	logic [1:0] sel_rl;
	logic [7:0] sel_rep [MaxPattern];
	logic [7:0] shifted [MaxPattern];
	logic [2:0] src_idx [MaxPattern];

	assign adv      = !out_valid_q || tx.ready;
	assign pending  = (fill_q == 2'(MaxPattern)) || (flush_q && fill_q != 2'd0);
	assign pop      = adv && (rep_cnt_q == 2'd0) && !pending && head_valid;
	assign emit_rep = adv && (rep_cnt_q != 2'd0);

	always_comb begin
		for (int i = 0; i < MaxPattern; i++) begin
			eff_win[i] = (pop && fill_q == 2'(i)) ? head.data_byte : win_q[i];
		end
	end

	assign eff_fill   = fill_q + {1'b0, pop};
	assign eff_flush  = flush_q || (pop && head.end_of_frame);
	assign decide     = adv && (rep_cnt_q == 2'd0) &&
		((eff_fill == 2'(MaxPattern)) || (eff_flush && eff_fill != 2'd0));
	assign active     = (cfg.rule_count > 3'(MaxRules)) ? 3'(MaxRules) : cfg.rule_count;
	assign match_esc  = !cfg.direction;

	// Per rule match against the window head; all rules compared in parallel.
	always_comb begin
		for (int j = 0; j < RuleRegs; j++) begin
			m_len[j] = pat_len(cfg.rules[j], match_esc);
			r_len[j] = pat_len(cfg.rules[j], !match_esc);
			hit[j]   = (3'(j) < active) && (m_len[j] != 2'd0) && (r_len[j] != 2'd0) &&
				(m_len[j] <= eff_fill);
			for (int k = 0; k < MaxPattern; k++) begin
				if ((2'(k) < m_len[j]) &&
				    (eff_win[k] != pat_byte(cfg.rules[j], match_esc, 2'(k)))) begin
					hit[j] = 1'b0;
				end
			end
		end
	end

	// First hit in table order wins; otherwise the head byte passes through.
	always_comb begin
		found      = 1'b0;
		sel_ml     = 2'd1;
		sel_rl     = 2'd1;
		sel_rep[0] = eff_win[0];
		for (int k = 1; k < MaxPattern; k++) begin
			sel_rep[k] = 8'd0;
		end
		for (int j = 0; j < RuleRegs; j++) begin
			if (!found && hit[j]) begin
				found  = 1'b1;
				sel_ml = m_len[j];
				sel_rl = r_len[j];
				for (int k = 0; k < MaxPattern; k++) begin
					sel_rep[k] = pat_byte(cfg.rules[j], !match_esc, 2'(k));
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MaxPattern; i++) begin
			src_idx[i] = 3'(i) + {1'b0, sel_ml};
			shifted[i] = (src_idx[i] < 3'(MaxPattern)) ? eff_win[src_idx[i][1:0]] : eff_win[i];
		end
	end

	assign frame_done = eff_flush && (eff_fill == sel_ml);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 2'd0;
			flush_q     <= 1'b0;
			rep_cnt_q   <= 2'd0;
			rep_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (decide) begin
				fill_q      <= eff_fill - sel_ml;
				flush_q     <= eff_flush && !frame_done;
				rep_cnt_q   <= sel_rl - 2'd1;
				rep_last_q  <= frame_done && (sel_rl != 2'd1);
				out_valid_q <= 1'b1;
			end else if (emit_rep) begin
				rep_cnt_q   <= rep_cnt_q - 2'd1;
				rep_last_q  <= rep_last_q && (rep_cnt_q != 2'd1);
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					fill_q  <= eff_fill;
					flush_q <= eff_flush;
				end
				if (tx.ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		priority if (decide) begin
			win_q      <= shifted;
			rep_q[0]   <= sel_rep[1];
			rep_q[1]   <= sel_rep[2];
			out_byte_q <= sel_rep[0];
			out_last_q <= frame_done && (sel_rl == 2'd1);
		end else if (emit_rep) begin
			rep_q[0]   <= rep_q[1];
			out_byte_q <= rep_q[0];
			out_last_q <= rep_last_q && (rep_cnt_q == 2'd1);
		end else if (pop) begin
			win_q <= eff_win;
		end else begin
			// Nothing moves: the window and the output word hold.
		end
	end

	assign tx.valid    = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.out_last = out_last_q;

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> fill_q != 2'd0)
		else $error("flush pending on an empty window");

	a_rep_last: assert property (@(posedge clk) disable iff (!arst_n)
		rep_last_q |-> rep_cnt_q != 2'd0)
		else $error("frame end mark held with no replacement bytes left");

	a_last_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> fill_q == 2'd0 && rep_cnt_q == 2'd0 && !flush_q)
		else $error("last word shown while frame bytes remain");

endmodule

>>> design/table_byte_stuffing_codec.sv
// Top level of the table byte stuffing codec: configuration registers and
// the front and back ends. Uses tbsc_pkg, tbsc_if, tbsc_front, tbsc_back.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+-------------------------------
//   rx      | in        | valid / ready | data_byte[7:0], end_of_frame
//   tx      | out       | valid / ready | out_byte[7:0], out_last
//   wr_*    | in        | wr_en only    | wr_index[2:0], wr_data[51:0]
//
// One input word is taken per cycle while the queue has room. A word is
// registered in the queue, and the first result word of the decision it
// completes goes through the output register before it shows on tx.
// A replacement of n bytes holds the back end until all n are out, and an
// end of frame drains the window one decision per cycle while tx is ready,
// so words wait in the four-entry queue and rx.ready falls only when full.
// Reset clears the queue, the window fill and the output register and sets
// the registers to escaping with no active rules. A stall on tx freezes the
// back end only; the front end keeps taking words until the queue is full.
module table_byte_stuffing_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	tbsc_in_if.sink                       rx,
	tbsc_out_if.source                    tx,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [tbsc_pkg::RuleWidth-1:0] wr_data
);
	import tbsc_pkg::*;

	logic                 direction_q;
	logic [2:0]           rule_count_q;
	rule_t [RuleRegs-1:0] rules_q;
	cfg_t                 cfg;
	item_t                head;
	logic                 head_valid;
	logic                 pop;

	// Register writes; an index past the last rule register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b1;
			rule_count_q <= 3'd0;
			rules_q      <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DIRECTION:  direction_q  <= wr_data[0];
				REG_RULE_COUNT: rule_count_q <= wr_data[2:0];
				REG_RULE_ZERO:  rules_q[0]   <= wr_data;
				REG_RULE_ONE:   rules_q[1]   <= wr_data;
				REG_RULE_TWO:   rules_q[2]   <= wr_data;
				REG_RULE_THREE: rules_q[3]   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.direction  = direction_q;
		cfg.rule_count = rule_count_q;
		cfg.rules      = rules_q;
	end

	// Front end: accepts words and queues them for the back end.
	tbsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// Back end: window, rule matching and output register.
	tbsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

>>> tb/table_byte_stuffing_codec_tb.sv
// Self-checking testbench for the table byte stuffing codec: directed and
// rule-aware random frames against an in-bench predictor of the conversion.
// Depends on tbsc_pkg, tbsc_if and the table_byte_stuffing_codec design.
`timescale 1ns / 1ps

module table_byte_stuffing_codec_tb;
	import tbsc_pkg::*;

	// Indexes that decode to no register; writes to them must be ignored.
	localparam logic [2:0] REG_UNUSED_SIX   = 3'd6;
	localparam logic [2:0] REG_UNUSED_SEVEN = 3'd7;

	// Cycles allowed after the last expected word before anything else is
	// done; covers words still moving through the queue and the window.
	localparam int unsigned DrainCycles = 20;
	// Cycles with no handshake on either channel before the run is abandoned.
	localparam int unsigned IdleLimit   = 3000;
	// Length of the long receiver hold-off that fills the input queue.
	localparam int unsigned HoldCycles  = 90;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} conv_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 wr_en;
	logic [2:0]           wr_index;
	logic [RuleWidth-1:0] wr_data;

	tbsc_in_if  rx ();
	tbsc_out_if tx ();

	table_byte_stuffing_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.tx       (tx),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: the testbench's own copy of the registers and of the
	// three-byte lookahead window.
	// ------------------------------------------------------------------
	logic        cfg_dir;
	logic [2:0]  cfg_count;
	rule_t       cfg_rule [RuleRegs];
	logic [7:0]  win [MaxPattern];
	int unsigned win_fill;

	conv_word_t  step_q [$];       // words produced by the word being predicted
	conv_word_t  converted_q [$];  // converted words still awaited on tx
	item_t       frame_q [$];      // input words not yet offered on rx
	logic [7:0]  byte_pool [4];    // small alphabet so that rules really match

	int unsigned items_queued;
	int unsigned words_in;
	int unsigned fail_count;

	function automatic int unsigned rule_len(rule_t r, bit esc);
		return esc ? 32'(r[27:26]) : 32'(r[1:0]);
	endfunction

	function automatic logic [7:0] rule_byte(rule_t r, bit esc, int unsigned k);
		rule_t sh;
		sh = r >> ((esc ? 28 : 2) + 8 * k);
		return sh[7:0];
	endfunction

	// Drops n bytes from the head of the window. The tail keeps stale bytes,
	// but only entries below the fill are ever looked at.
	function automatic void shift_window(int unsigned n);
		int unsigned i;
		for (i = 0; i + n < MaxPattern; i++)
			win[i] = win[i + n];
		win_fill = win_fill - n;
	endfunction

	// One decision on the window head: the first active rule whose match side
	// equals the head wins, otherwise the head byte goes through untouched.
	// A rule with either length zero is switched off, and a pattern longer
	// than what the window holds cannot match, so nothing crosses a frame end.
	function automatic void decide_head();
		int unsigned active, ml, rl, j, k;
		bit          match_esc, hit, done;
		rule_t       r;
		active = 32'(cfg_count);
		if (active > MaxRules)
			active = MaxRules;
		if (active > RuleRegs)
			active = RuleRegs;
		match_esc = !cfg_dir;
		done = 1'b0;
		for (j = 0; j < active && !done; j++) begin
			r  = cfg_rule[j];
			ml = rule_len(r, match_esc);
			rl = rule_len(r, !match_esc);
			if (ml != 0 && rl != 0 && ml <= win_fill && ml <= MaxPattern) begin
				hit = 1'b1;
				for (k = 0; k < ml; k++)
					if (win[k] != rule_byte(r, match_esc, k))
						hit = 1'b0;
				if (hit) begin
					for (k = 0; k < rl; k++)
						step_q.push_back({rule_byte(r, !match_esc, k), 1'b0});
					shift_window(ml);
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			step_q.push_back({win[0], 1'b0});
			shift_window(1);
		end
	endfunction

	// Works out the converted words caused by one accepted input word. An end
	// of frame flushes the whole window and marks the last word it produces.
	function automatic void convert_word(logic [7:0] b, logic eof);
		conv_word_t w;
		step_q.delete();
		if (win_fill < MaxPattern) begin
			win[win_fill] = b;
			win_fill++;
		end
		if (eof) begin
			while (win_fill > 0)
				decide_head();
			w = step_q.pop_back();
			w.last = 1'b1;
			step_q.push_back(w);
		end else if (win_fill >= MaxPattern) begin
			decide_head();
		end
		while (step_q.size() > 0)
			converted_q.push_back(step_q.pop_front());
	endfunction

	function automatic logic [7:0] pool_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0)
			b = 8'($urandom_range(0, 255));
		else
			b = byte_pool[$urandom_range(0, 3)];
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers, all called from the main initial block.
	// ------------------------------------------------------------------

	// Register write on the plain write port. The block is idle whenever this
	// is called, so the predictor copy can follow at once.
	task automatic cfg_write(logic [2:0] idx, logic [RuleWidth-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en    <= 1'b0;
		case (idx)
			REG_DIRECTION:  cfg_dir     = val[0];
			REG_RULE_COUNT: cfg_count   = val[2:0];
			REG_RULE_ZERO:  cfg_rule[0] = val;
			REG_RULE_ONE:   cfg_rule[1] = val;
			REG_RULE_TWO:   cfg_rule[2] = val;
			REG_RULE_THREE: cfg_rule[3] = val;
			default: ;
		endcase
	endtask

	function automatic rule_t make_rule(int unsigned raw_len, logic [23:0] raw,
			int unsigned esc_len, logic [23:0] esc);
		rule_t r;
		r        = '0;
		r[1:0]   = 2'(raw_len);
		r[25:2]  = raw;
		r[27:26] = 2'(esc_len);
		r[51:28] = esc;
		return r;
	endfunction

	task automatic add_word(logic [7:0] b, logic eof);
		item_t it;
		it.data_byte    = b;
		it.end_of_frame = eof;
		frame_q.push_back(it);
		items_queued++;
	endtask

	// A frame built mostly from the current rules' patterns, so that matches,
	// near misses and patterns cut short by the frame end all turn up.
	task automatic add_frame(int unsigned len);
		logic [7:0]  fb [$];
		int unsigned k, pl, pick;
		bit          side;
		rule_t       r;
		while (fb.size() < len) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				r    = cfg_rule[$urandom_range(0, RuleRegs - 1)];
				side = 1'($urandom_range(0, 1));
				pl   = rule_len(r, side);
				for (k = 0; k < pl && fb.size() < len; k++)
					fb.push_back(rule_byte(r, side, k));
			end else if (pick < 8) begin
				fb.push_back(pool_byte());
			end else begin
				fb.push_back(8'($urandom_range(0, 255)));
			end
		end
		while (fb.size() > 1)
			add_word(fb.pop_front(), 1'b0);
		add_word(fb.pop_front(), 1'b1);
	endtask

	task automatic random_config();
		logic [RuleWidth-1:0] v;
		int unsigned          i, k;
		for (i = 0; i < 4; i++)
			byte_pool[i] = 8'($urandom_range(0, 255));
		// Junk in the unused upper bits checks that only the low bits count.
		v = RuleWidth'({$urandom, $urandom});
		v[0] = 1'($urandom_range(0, 1));
		cfg_write(REG_DIRECTION, v);
		v = RuleWidth'({$urandom, $urandom});
		v[2:0] = 3'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 4);
		cfg_write(REG_RULE_COUNT, v);
		for (i = 0; i < RuleRegs; i++) begin
			v = '0;
			v[1:0]   = 2'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
			v[27:26] = 2'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
			for (k = 0; k < 3; k++) begin
				v[2 + 8 * k +: 8]  = pool_byte();
				v[28 + 8 * k +: 8] = pool_byte();
			end
			cfg_write(3'(REG_RULE_ZERO + i), v);
		end
		if ($urandom_range(0, 1))
			cfg_write($urandom_range(0, 1) ? REG_UNUSED_SIX : REG_UNUSED_SEVEN,
				RuleWidth'({$urandom, $urandom}));
	endtask

	// Mostly well-formed frames, with a share of raw noise where the end of
	// frame flag falls anywhere. The phase always closes on an end of frame so
	// that the window is empty before the registers change.
	task automatic random_phase(int unsigned words);
		int unsigned start;
		start = items_queued;
		while (items_queued - start < words) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 5))
					add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				add_frame($urandom_range(1, 10));
			end
		end
		add_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Waits until every queued word has been taken and every converted word
	// has come out, then lets the block settle.
	task automatic drain();
		while (words_in != items_queued)
			@(posedge clk);
		while (converted_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued words in bursts of random length with random
	// gaps between them. A word stays on the channel until it is taken, and
	// the predictor runs at the edge where it is accepted.
	// ------------------------------------------------------------------
	int unsigned burst_left;
	int unsigned gap_left;
	item_t       next_item;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx.valid && rx.ready) begin
				convert_word(rx.data_byte, rx.end_of_frame);
				words_in++;
			end
			if (!rx.valid || rx.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					rx.valid <= 1'b0;
				end else if (frame_q.size() > 0) begin
					next_item = frame_q.pop_front();
					rx.valid        <= 1'b1;
					rx.data_byte    <= next_item.data_byte;
					rx.end_of_frame <= next_item.end_of_frame;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					rx.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver and checker. Ready follows a pattern that changes from one
	// segment to the next: always ready, coin toss, mostly stalled, or a
	// regular duty cycle. Once, part way through the random words, it holds
	// off for a long stretch while the driver keeps offering, so the input
	// queue fills and rx.ready must fall.
	// ------------------------------------------------------------------
	int unsigned seg_left;
	int unsigned seg_mode;
	int unsigned hold_left;
	bit          hold_done;
	int unsigned beat;
	conv_word_t  exp_word;

	always @(posedge clk) begin
		if (arst_n) begin
			if (tx.valid && tx.ready) begin
				if (converted_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual byte %02h last %0b",
						$time, tx.out_byte, tx.out_last);
					fail_count++;
				end else begin
					exp_word = converted_q.pop_front();
					if (tx.out_byte !== exp_word.data) begin
						$display("%0t: out_byte mismatch, expected %02h actual %02h",
							$time, exp_word.data, tx.out_byte);
						fail_count++;
					end
					if (tx.out_last !== exp_word.last) begin
						$display("%0t: out_last mismatch, expected %0b actual %0b",
							$time, exp_word.last, tx.out_last);
						fail_count++;
					end
				end
			end
			if (!hold_done && words_in >= 200) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 80);
			end else begin
				seg_left--;
			end
			beat++;
			if (hold_left > 0) begin
				hold_left--;
				tx.ready <= 1'b0;
			end else begin
				case (seg_mode)
					0: tx.ready <= 1'b1;
					1: tx.ready <= 1'($urandom_range(0, 1));
					2: tx.ready <= ($urandom_range(0, 3) == 0);
					default: tx.ready <= (beat % 3 != 0);
				endcase
			end
		end
	end

	// Watchdog: a run that stops moving words on both channels has hung.
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx.valid && rx.ready) || (tx.valid && tx.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, directed phases, then random phases, each phase
	// set up while the block is idle.
	// ------------------------------------------------------------------
	int unsigned p;

	initial begin
		arst_n          = 1'b0;
		rx.valid        = 1'b0;
		rx.data_byte    = '0;
		rx.end_of_frame = 1'b0;
		tx.ready        = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		cfg_dir   = 1'b1;
		cfg_count = '0;
		for (p = 0; p < RuleRegs; p++)
			cfg_rule[p] = '0;
		for (p = 0; p < MaxPattern; p++)
			win[p] = '0;
		win_fill = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Registers as left by reset: escaping with no active rules, so every
		// byte passes through. A one-byte frame is flushed straight away.
		add_word(8'h00, 1'b0);
		add_word(8'hFF, 1'b1);
		add_word(8'h5A, 1'b1);
		drain();

		// Escaping with a rule count above the number of rule registers. The
		// last rule has an escaped length of zero and so must stay inactive.
		cfg_write(REG_DIRECTION, 52'd1);
		cfg_write(REG_RULE_COUNT, 52'd7);
		cfg_write(REG_RULE_ZERO,  make_rule(1, 24'h0000C0, 2, 24'h00DCDB));
		cfg_write(REG_RULE_ONE,   make_rule(1, 24'h0000AA, 3, 24'hE3E2E1));
		cfg_write(REG_RULE_TWO,   make_rule(3, 24'h7E7D7E, 1, 24'h000055));
		cfg_write(REG_RULE_THREE, make_rule(1, 24'h0000FF, 0, 24'h123456));
		// Three single-byte expansions to three bytes in one flush: the most
		// words a single input word can cause.
		add_word(8'hAA, 1'b0);
		add_word(8'hAA, 1'b0);
		add_word(8'hAA, 1'b1);
		add_word(8'hC0, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'h00, 1'b1);
		add_word(8'h7E, 1'b0);
		add_word(8'h7D, 1'b0);
		add_word(8'h7E, 1'b0);
		add_word(8'h01, 1'b1);
		// The three-byte pattern cut short by the frame end must not match.
		add_word(8'h7E, 1'b0);
		add_word(8'h7D, 1'b1);
		drain();

		// Same rules, restoring.
		cfg_write(REG_DIRECTION, 52'd0);
		add_word(8'hDB, 1'b0);
		add_word(8'hDC, 1'b0);
		add_word(8'h55, 1'b1);
		add_word(8'hE1, 1'b0);
		add_word(8'hE2, 1'b0);
		add_word(8'hE3, 1'b1);
		drain();

		// Every register at all ones, then every register but the rule count at
		// all zeros, with unknown indexes written in between.
		cfg_write(REG_DIRECTION,  '1);
		cfg_write(REG_RULE_COUNT, '1);
		cfg_write(REG_RULE_ZERO,  '1);
		cfg_write(REG_RULE_ONE,   '1);
		cfg_write(REG_RULE_TWO,   '1);
		cfg_write(REG_RULE_THREE, '1);
		cfg_write(REG_UNUSED_SIX, '1);
		add_word(8'hFF, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'hFF, 1'b1);
		drain();
		cfg_write(REG_UNUSED_SEVEN, '0);
		cfg_write(REG_DIRECTION,  '0);
		cfg_write(REG_RULE_ZERO,  '0);
		cfg_write(REG_RULE_ONE,   '0);
		cfg_write(REG_RULE_TWO,   '0);
		cfg_write(REG_RULE_THREE, '0);
		add_word(8'h00, 1'b1);
		drain();

		for (p = 0; p < 8; p++) begin
			random_config();
			random_phase(50);
			drain();
		end

		if (fail_count == 0 && converted_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> table_byte_stuffing_codec.f
design/tbsc_pkg.sv
design/tbsc_if.sv
design/tbsc_front.sv
design/tbsc_back.sv
design/table_byte_stuffing_codec.sv
tb/table_byte_stuffing_codec_tb.sv
